// ----- src/gpio_port_with_config_lock_macros.svh -----
// assertion macros for the gpio port with configuration lock
`ifndef GPIO_PORT_WITH_CONFIG_LOCK_MACROS_SVH
`define GPIO_PORT_WITH_CONFIG_LOCK_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define GPLK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define GPLK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/gplk_pkg.sv -----
`timescale 1ns / 1ps
package gplk_pkg;

	localparam int PIN_COUNT_DEF = 16;
	localparam int PINS_MAX = 16;
	localparam int IN_DATA_W = 48;
	localparam int IN_USER_W = 4;
	localparam int OUT_DATA_W = 56;
	localparam int KEY_BIT = 16;

	localparam logic [31:0] CFG_RESET = 32'h4444_4444;
	localparam logic [3:0] NIBBLE = 4'hF;

	localparam logic ACT_READ = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef enum logic [2:0] {
		REG_CRL = 3'd0,
		REG_CRH = 3'd1,
		REG_IDR = 3'd2,
		REG_ODR = 3'd3,
		REG_BSRR = 3'd4,
		REG_BRR = 3'd5,
		REG_LCKR = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_FIRST = 2'd1,
		PH_SECOND = 2'd2
	} key_phase_t;

	typedef struct packed {
		logic action;
		logic [2:0] reg_index;
		logic [31:0] write_data;
		logic [15:0] pin_levels;
	} item_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [15:0] out_levels;
		logic lock_active;
	} item_out_t;

endpackage

// ----- src/gplk_in_reg.sv -----
`timescale 1ns / 1ps
module gplk_in_reg (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [gplk_pkg::IN_DATA_W-1:0] s_tdata,
	input logic [gplk_pkg::IN_USER_W-1:0] s_tuser,
	input logic adv,
	output logic valid_s1,
	output gplk_pkg::item_in_t item_s1
);
	import gplk_pkg::*;

	logic take;

	assign s_tready = !valid_s1 || adv;
	assign take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action <= s_tuser[0];
			item_s1.reg_index <= s_tuser[3:1];
			item_s1.write_data <= s_tdata[31:0];
			item_s1.pin_levels <= s_tdata[47:32];
		end
	end

endmodule

// ----- src/gplk_regfile.sv -----
`timescale 1ns / 1ps
module gplk_regfile #(
	parameter int PIN_COUNT = gplk_pkg::PIN_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input gplk_pkg::item_in_t item,
	output gplk_pkg::item_out_t res
);
	import gplk_pkg::*;

	localparam logic [PINS_MAX-1:0] PIN_MASK =
		PINS_MAX'((33'd1 << PIN_COUNT) - 33'd1);

	logic [31:0] cfg_low_q, cfg_high_q, cfg_low_d, cfg_high_d;
	logic [15:0] latch_q, latch_d;
	logic [15:0] lock_bits_q, lock_bits_d;
	logic lock_key_q, lock_key_d;
	key_phase_t phase_q, phase_d;

	logic [31:0] frz_low, frz_high;
	logic [31:0] rd;
	logic [15:0] lk_mask;
	logic lk_key, lk_same;
	logic is_wr;

	assign is_wr = (item.action == ACT_WRITE);
	assign lk_mask = item.write_data[15:0] & PIN_MASK;
	assign lk_key = item.write_data[KEY_BIT];
	assign lk_same = (lk_mask == lock_bits_q);

	// nibbles held by the lock
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			frz_low[4*i +: 4] = (lock_key_q && lock_bits_q[i]) ? NIBBLE : 4'h0;
			frz_high[4*i +: 4] = (lock_key_q && lock_bits_q[8+i]) ? NIBBLE : 4'h0;
		end
	end

	always_comb begin
		rd = '0;
		if (!is_wr) begin
			case (reg_idx_t'(item.reg_index))
				REG_CRL: rd = cfg_low_q;
				REG_CRH: rd = cfg_high_q;
				REG_IDR: rd = {16'h0, item.pin_levels & PIN_MASK};
				REG_ODR: rd = {16'h0, latch_q};
				REG_LCKR: rd = {15'h0, lock_key_q, lock_bits_q};
				default: rd = '0;
			endcase
		end
	end

	always_comb begin
		cfg_low_d = cfg_low_q;
		cfg_high_d = cfg_high_q;
		latch_d = latch_q;
		lock_bits_d = lock_bits_q;
		lock_key_d = lock_key_q;
		phase_d = phase_q;
		if (is_wr) begin
			case (reg_idx_t'(item.reg_index))
				REG_CRL: cfg_low_d = (cfg_low_q & frz_low) | (item.write_data & ~frz_low);
				REG_CRH: cfg_high_d = (cfg_high_q & frz_high) | (item.write_data & ~frz_high);
				REG_ODR: latch_d = item.write_data[15:0] & PIN_MASK;
				REG_BSRR: latch_d = ((latch_q & ~item.write_data[31:16])
					| item.write_data[15:0]) & PIN_MASK;
				REG_BRR: latch_d = latch_q & ~item.write_data[15:0] & PIN_MASK;
				REG_LCKR: begin
					if (!lock_key_q) begin
						lock_bits_d = lk_mask;
						if (phase_q == PH_FIRST && !lk_key && lk_same) begin
							phase_d = PH_SECOND;
						end else if (phase_q == PH_SECOND && lk_key && lk_same) begin
							phase_d = PH_IDLE;
							lock_key_d = 1'b1;
						end else begin
							phase_d = lk_key ? PH_FIRST : PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_low_q <= CFG_RESET;
			cfg_high_q <= CFG_RESET;
			latch_q <= '0;
			lock_bits_q <= '0;
			lock_key_q <= 1'b0;
			phase_q <= PH_IDLE;
		end else if (fire) begin
			cfg_low_q <= cfg_low_d;
			cfg_high_q <= cfg_high_d;
			latch_q <= latch_d;
			lock_bits_q <= lock_bits_d;
			lock_key_q <= lock_key_d;
			phase_q <= phase_d;
		end
	end

	assign res.read_data = rd;
	assign res.out_levels = latch_d;
	assign res.lock_active = lock_key_d;

endmodule

// ----- src/gplk_out_reg.sv -----
`timescale 1ns / 1ps
module gplk_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input gplk_pkg::item_out_t res,
	output logic out_ready,
	output logic m_tvalid,
	input logic m_tready,
	output logic [gplk_pkg::OUT_DATA_W-1:0] m_tdata
);
	import gplk_pkg::*;

	item_out_t res_q;

	assign out_ready = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ready) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tdata = {7'h0, res_q.lock_active, res_q.out_levels, res_q.read_data};

endmodule

// ----- src/gpio_port_with_config_lock.sv -----
`timescale 1ns / 1ps
// sixteen-pin gpio port seen as a register file: each input item is one read or write of
// crl, crh, idr, odr, bsrr, brr or lckr, and each gives exactly one result item with the
// read data (zero on writes), the output latch after the access and the lock key state.
// one item is taken every cycle while results are taken; a result is presented when its item
// moves from the input register into the result register, and the port state is updated on
// that same move. a stalled result holds the input once both registers are full. the lckr
// key sequence (bit 16 set, clear, set with the same mask) freezes the lock bits and the
// configuration nibbles of locked pins until reset.
module gpio_port_with_config_lock #(
	parameter int PIN_COUNT = gplk_pkg::PIN_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [gplk_pkg::IN_DATA_W-1:0] s_tdata,   // write_data, pin_levels
	input logic [gplk_pkg::IN_USER_W-1:0] s_tuser,   // action, reg_index
	output logic m_tvalid,
	input logic m_tready,
	output logic [gplk_pkg::OUT_DATA_W-1:0] m_tdata  // read_data, out_levels, lock_active
);
	import gplk_pkg::*;

	logic valid_s1;
	item_in_t item_s1;
	item_out_t res;
	logic out_ready;
	logic adv;

	assign adv = valid_s1 && out_ready;

	gplk_in_reg u_in (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.adv(out_ready),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	gplk_regfile #(
		.PIN_COUNT(PIN_COUNT)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.fire(adv),
		.item(item_s1),
		.res(res)
	);

	gplk_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(adv),
		.res(res),
		.out_ready(out_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ----- src/gplk_checker.sv -----
`timescale 1ns / 1ps
`include "gpio_port_with_config_lock_macros.svh"
module gplk_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [gplk_pkg::IN_DATA_W-1:0] s_tdata,
	input logic [gplk_pkg::IN_USER_W-1:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [gplk_pkg::OUT_DATA_W-1:0] m_tdata
);
	import gplk_pkg::*;

	logic in_acc, out_acc;
	logic [2:0] cnt_q;
	logic lock_seen_q;
	logic unused_in;

	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign unused_in = ^{s_tdata, s_tuser};

	// items in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + 3'd1;
		end else if (!in_acc && out_acc) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_seen_q <= 1'b0;
		end else if (out_acc && m_tdata[KEY_BIT+32]) begin
			lock_seen_q <= 1'b1;
		end
	end

	`GPLK_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`GPLK_ASSERT_IMP(a_depth, clk, arst_n, 1'b1, cnt_q <= 3'd2 || unused_in != unused_in, "more than two items in flight")
	`GPLK_ASSERT_IMP(a_empty, clk, arst_n, cnt_q == 3'd0, !m_tvalid, "result without an accepted item")
	`GPLK_ASSERT_IMP(a_lock, clk, arst_n, m_tvalid && lock_seen_q, m_tdata[KEY_BIT+32], "lock key dropped before reset")

endmodule

bind gpio_port_with_config_lock gplk_checker u_gplk_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import gplk_pkg::*;

	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int LOCK_AT = 1250;
	localparam int DRAIN_EVERY = 450;

	typedef struct {
		item_in_t acc;
		bit drain;
	} bus_access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;   // write_data, pin_levels
	logic [IN_USER_W-1:0] s_tuser = '0;   // action, reg_index
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;       // read_data, out_levels, lock_active

	bus_access_t access_queue[$];
	item_out_t awaited_results[$];
	item_in_t cur_access;
	int push_cnt = 0;
	int sent_cnt = 0;
	int recv_cnt = 0;
	int err_cnt = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int idle_cycles = 0;
	bit long_hold_done = 1'b0;

	logic [31:0] port_crl;
	logic [31:0] port_crh;
	logic [15:0] port_odr;
	logic [15:0] port_lock_mask;
	logic port_key_on;
	key_phase_t port_phase;

	gpio_port_with_config_lock u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	function automatic void port_reset();
		port_crl = CFG_RESET;
		port_crh = CFG_RESET;
		port_odr = '0;
		port_lock_mask = '0;
		port_key_on = 1'b0;
		port_phase = PH_IDLE;
	endfunction

	// nibbles held by the lock for the eight pins from base up
	function automatic logic [31:0] frozen_nibbles(int base);
		logic [31:0] f;
		f = '0;
		if (port_key_on) begin
			for (int i = 0; i < 8; i++) begin
				if (port_lock_mask[base + i])
					f[4*i +: 4] = NIBBLE;
			end
		end
		return f;
	endfunction

	function automatic item_out_t predict_access(item_in_t acc);
		item_out_t res;
		logic [31:0] f;
		logic [15:0] msk;
		logic key;
		res = '0;
		if (acc.action == ACT_READ) begin
			case (acc.reg_index)
				REG_CRL: res.read_data = port_crl;
				REG_CRH: res.read_data = port_crh;
				REG_IDR: res.read_data = {16'd0, acc.pin_levels};
				REG_ODR: res.read_data = {16'd0, port_odr};
				REG_LCKR: res.read_data = {15'd0, port_key_on, port_lock_mask};
				default: res.read_data = '0;
			endcase
		end else begin
			case (acc.reg_index)
				REG_CRL: begin
					f = frozen_nibbles(0);
					port_crl = (port_crl & f) | (acc.write_data & ~f);
				end
				REG_CRH: begin
					f = frozen_nibbles(8);
					port_crh = (port_crh & f) | (acc.write_data & ~f);
				end
				REG_ODR: port_odr = acc.write_data[15:0];
				REG_BSRR: port_odr = (port_odr & ~acc.write_data[31:16]) | acc.write_data[15:0];
				REG_BRR: port_odr = port_odr & ~acc.write_data[15:0];
				REG_LCKR: begin
					msk = acc.write_data[15:0];
					key = acc.write_data[KEY_BIT];
					if (!port_key_on) begin
						if (port_phase == PH_FIRST && !key && msk == port_lock_mask) begin
							port_phase = PH_SECOND;
						end else if (port_phase == PH_SECOND && key && msk == port_lock_mask) begin
							port_phase = PH_IDLE;
							port_key_on = 1'b1;
						end else begin
							port_phase = key ? PH_FIRST : PH_IDLE;
						end
						port_lock_mask = msk;
					end
				end
				default: ;
			endcase
		end
		res.out_levels = port_odr;
		res.lock_active = port_key_on;
		return res;
	endfunction

	function automatic item_in_t mk(logic act, logic [2:0] idx, logic [31:0] d, logic [15:0] lv);
		item_in_t a;
		a.action = act;
		a.reg_index = idx;
		a.write_data = d;
		a.pin_levels = lv;
		return a;
	endfunction

	function automatic item_in_t rand_access();
		logic [31:0] d;
		case ($urandom_range(0, 9))
			0: d = '0;
			1: d = '1;
			default: d = $urandom;
		endcase
		return mk(1'($urandom), 3'($urandom), d, 16'($urandom));
	endfunction

	function automatic void queue_access(item_in_t a);
		bus_access_t st;
		st.acc = a;
		st.drain = (push_cnt % DRAIN_EVERY == 300);
		access_queue.push_back(st);
		push_cnt++;
	endfunction

	// any access that leaves the key sequence alone
	function automatic void side_access();
		item_in_t a;
		a = rand_access();
		if (a.action == ACT_WRITE && a.reg_index == REG_LCKR)
			a.action = ACT_READ;
		queue_access(a);
	endfunction

	function automatic void lock_attempt(bit complete);
		logic [15:0] m;
		logic [15:0] flip;
		int how;
		m = 16'($urandom);
		flip = 16'd1 << $urandom_range(0, 15);
		how = complete ? 6 : $urandom_range(0, 5);
		queue_access(mk(ACT_WRITE, REG_LCKR, {15'd0, 1'b1, m}, 16'($urandom)));
		if (how == 0)
			return;
		if ($urandom_range(0, 1))
			side_access();
		queue_access(mk(ACT_WRITE, REG_LCKR,
			{15'd0, how == 2, (how == 5) ? (m ^ flip) : m}, 16'($urandom)));
		if (how == 1)
			return;
		if ($urandom_range(0, 1))
			side_access();
		queue_access(mk(ACT_WRITE, REG_LCKR,
			{15'd0, how != 4, (how == 3) ? (m ^ flip) : m}, 16'($urandom)));
	endfunction

	function automatic int next_gap(int cnt);
		int r;
		if ((cnt / 150) % 3 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : driver
		bus_access_t nxt;
		logic give;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap = 0;
			port_reset();
		end else begin
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(predict_access(cur_access));
				sent_cnt++;
				send_gap = next_gap(sent_cnt);
			end
			if (!(s_tvalid && !s_tready)) begin
				give = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (access_queue.size() > 0) begin
					if (!access_queue[0].drain || awaited_results.size() == 0) begin
						nxt = access_queue.pop_front();
						cur_access = nxt.acc;
						s_tdata <= {nxt.acc.pin_levels, nxt.acc.write_data};
						s_tuser <= {nxt.acc.reg_index, nxt.acc.action};
						give = 1'b1;
					end
				end
				s_tvalid <= give;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		item_out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				recv_cnt++;
				if (awaited_results.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
				end else begin
					want = awaited_results.pop_front();
					check_field("read_data", want.read_data, m_tdata[31:0]);
					check_field("out_levels", 32'(want.out_levels), 32'(m_tdata[47:32]));
					check_field("lock_active", 32'(want.lock_active), 32'(m_tdata[48]));
				end
				recv_gap = next_gap(recv_cnt);
				if (!long_hold_done && recv_cnt == 600) begin
					recv_gap = LONG_HOLD;
					long_hold_done = 1'b1;
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		bit lock_sent;
		lock_sent = 1'b0;

		// reset state, read paths and the odd registers
		queue_access(mk(ACT_READ, REG_CRL, '0, 16'h0000));
		queue_access(mk(ACT_READ, REG_CRH, '1, 16'hFFFF));
		queue_access(mk(ACT_READ, REG_IDR, '0, 16'hFFFF));
		queue_access(mk(ACT_READ, REG_IDR, '0, 16'h0000));
		queue_access(mk(ACT_READ, REG_IDR, '1, 16'hA55A));
		queue_access(mk(ACT_WRITE, REG_IDR, '1, 16'hFFFF));
		queue_access(mk(ACT_WRITE, REG_ODR, '1, 16'h0000));
		queue_access(mk(ACT_READ, REG_ODR, '0, 16'h0000));
		queue_access(mk(ACT_READ, REG_BSRR, '1, 16'h0000));
		queue_access(mk(ACT_READ, REG_BRR, '1, 16'h0000));
		queue_access(mk(ACT_READ, REG_SPARE, '1, 16'hFFFF));
		queue_access(mk(ACT_WRITE, REG_SPARE, '1, 16'hFFFF));
		// set and reset on the same pin: set wins
		queue_access(mk(ACT_WRITE, REG_BSRR, 32'hFFFF_0000, 16'h0000));
		queue_access(mk(ACT_WRITE, REG_BSRR, 32'h8001_8001, 16'h0000));
		queue_access(mk(ACT_WRITE, REG_BRR, 32'hFFFF_8000, 16'h0000));
		queue_access(mk(ACT_WRITE, REG_CRL, 32'h0000_0000, 16'h0000));
		queue_access(mk(ACT_WRITE, REG_CRH, 32'hFFFF_FFFF, 16'h0000));
		queue_access(mk(ACT_READ, REG_CRL, '0, 16'h0000));
		queue_access(mk(ACT_READ, REG_CRH, '0, 16'h0000));
		// key sequence aborted by a wrong mask, then by a missing key bit
		queue_access(mk(ACT_WRITE, REG_LCKR, 32'h0001_00F0, 16'h0000));
		queue_access(mk(ACT_READ, REG_LCKR, '0, 16'h0000));
		queue_access(mk(ACT_WRITE, REG_LCKR, 32'h0000_0F00, 16'h0000));
		queue_access(mk(ACT_WRITE, REG_LCKR, 32'h0001_00F0, 16'h0000));
		queue_access(mk(ACT_WRITE, REG_LCKR, 32'h0000_00F0, 16'h0000));
		queue_access(mk(ACT_WRITE, REG_LCKR, 32'h0000_00F0, 16'h0000));

		while (push_cnt < 25 + RANDOM_ITEMS) begin
			if (!lock_sent && push_cnt >= LOCK_AT) begin
				lock_attempt(1'b1);
				lock_sent = 1'b1;
			end else if ($urandom_range(0, 99) < 15) begin
				lock_attempt(1'b0);
			end else begin
				queue_access(rand_access());
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (access_queue.size() > 0 || s_tvalid)
			@(posedge clk);
		while (awaited_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/gplk_pkg.sv
src/gplk_in_reg.sv
src/gplk_regfile.sv
src/gplk_out_reg.sv
src/gpio_port_with_config_lock.sv
src/gplk_checker.sv
test/testbench.sv
